// ===== src/dsc_pkg.sv =====
// Shared types and constants for the digitizer sample calibrator.
// Used by every module of the block; no dependencies.
package dsc_pkg;

  // Waveform length limit and derived index width (index runs to MAX_SAMPLES)
  localparam int MAX_SAMPLES = 256;
  localparam int IDX_W       = $clog2(MAX_SAMPLES + 1);

  // Field widths
  localparam int COUNT_W  = 10;
  localparam int BASE_W   = 16;
  localparam int GAIN_W   = 24;
  localparam int VOLT_W   = 41;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  // Converter full scale
  localparam logic [COUNT_W-1:0] ADC_MAX = 10'd1023;

  // Front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ST_PLAIN = 2'd0,
    ST_SAT   = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE   = 3'd0,
    REG_GAIN       = 3'd1,
    REG_SAT_MARGIN = 3'd2,
    REG_UND_MARGIN = 3'd3,
    REG_CLIP       = 3'd4,
    REG_DROP_PLAIN = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_SAMPLE = 2'd0,
    PH_RUN_A  = 2'd1,
    PH_RUN_B  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BASE_W-1:0]  baseline_level;
    logic [GAIN_W-1:0]  gain_factor;
    logic [COUNT_W-1:0] saturation_margin;
    logic [COUNT_W-1:0] undershoot_margin;
    logic [COUNT_W-1:0] clip_level;
    logic               drop_plain_runs;
  } cfg_t;

  typedef struct packed {
    status_t          st;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] stop;
  } run_t;

  // One classified sample with the run records it closes
  typedef struct packed {
    logic [COUNT_W-1:0] counts;
    status_t            st;
    logic               emit_a;
    run_t               run_a;
    logic               emit_b;
    run_t               run_b;
  } entry_t;

endpackage

// ===== src/dsc_fifo.sv =====
// Short queue between the classifier front and the output back end.
// Depends on dsc_pkg (entry_t, QDEPTH).
module dsc_fifo import dsc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/dsc_front.sv =====
// Input side: classifies each sample and keeps the run bookkeeping.
// Depends on dsc_pkg; feeds dsc_fifo.
module dsc_front import dsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COUNT_W-1:0] in_counts,
  input  logic               in_last,
  input  logic               q_full,
  output logic               push,
  output entry_t             push_data
);

  logic [IDX_W-1:0] sample_index_r, sample_index_nxt;
  status_t          run_st_r, run_st_nxt;
  logic [IDX_W-1:0] run_first_r, run_first_nxt;

  logic [COUNT_W:0] sat_sum;
  status_t          st;
  logic             last;
  status_t          open_st;
  logic [IDX_W-1:0] open_first;
  logic             change;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Sample status; saturation wins over undershoot
  assign sat_sum = {1'b0, in_counts} + {1'b0, cfg.saturation_margin};
  always_comb begin
    priority if (sat_sum >= {1'b0, cfg.clip_level}) begin
      st = ST_SAT;
    end else if (in_counts <= cfg.undershoot_margin) begin
      st = ST_UNDER;
    end else begin
      st = ST_PLAIN;
    end
  end

  // Run tracking and record decisions
  always_comb begin
    last   = in_last || (sample_index_r >= IDX_W'(MAX_SAMPLES - 1));
    change = (sample_index_r != '0) && (st != run_st_r);

    if (sample_index_r == '0 || change) begin
      open_st    = st;
      open_first = sample_index_r;
    end else begin
      open_st    = run_st_r;
      open_first = run_first_r;
    end

    push_data.counts       = in_counts;
    push_data.st           = st;
    push_data.emit_a       = change && !(run_st_r == ST_PLAIN && cfg.drop_plain_runs);
    push_data.run_a.st     = run_st_r;
    push_data.run_a.first  = run_first_r;
    push_data.run_a.stop   = sample_index_r;
    push_data.emit_b       = last && !(open_st == ST_PLAIN && cfg.drop_plain_runs);
    push_data.run_b.st     = open_st;
    push_data.run_b.first  = open_first;
    push_data.run_b.stop   = sample_index_r + 1'b1;

    sample_index_nxt = sample_index_r;
    run_st_nxt       = run_st_r;
    run_first_nxt    = run_first_r;
    if (push) begin
      if (last) begin
        sample_index_nxt = '0;
        run_st_nxt       = ST_PLAIN;
        run_first_nxt    = '0;
      end else begin
        sample_index_nxt = sample_index_r + 1'b1;
        run_st_nxt       = open_st;
        run_first_nxt    = open_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      run_st_r       <= ST_PLAIN;
      run_first_r    <= '0;
    end else begin
      sample_index_r <= sample_index_nxt;
      run_st_r       <= run_st_nxt;
      run_first_r    <= run_first_nxt;
    end
  end

endmodule

// ===== src/dsc_back.sv =====
// Output side: calibrates the voltage and sequences up to three results
// per queued sample into the output register. Depends on dsc_pkg.
module dsc_back import dsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [BASE_W-1:0]        baseline_level,
  input  logic [GAIN_W-1:0]        gain_factor,
  input  entry_t                   head,
  input  logic                     q_empty,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_record_kind,
  output logic signed [VOLT_W-1:0] out_voltage,
  output logic [1:0]               out_sample_status,
  output logic [1:0]               out_run_status,
  output logic [IDX_W-1:0]         out_run_first,
  output logic [IDX_W-1:0]         out_run_end,
  output logic                     out_item_done
);

  // Sample being sequenced
  logic                     cur_valid_r, cur_valid_nxt;
  entry_t                   cur_r;
  logic signed [VOLT_W-1:0] volt_r;
  phase_t                   phase_r, phase_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic                     kind_r;
  logic signed [VOLT_W-1:0] ovolt_r;
  logic [1:0]               sst_r, rst_r;
  logic [IDX_W-1:0]         first_r, end_r;
  logic                     done_r;

  logic signed [BASE_W:0]   diff;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [BASE_W+GAIN_W+1:0] prod;

  logic   out_load, emit, cur_last, cur_take;
  phase_t phase_after;
  run_t   sel_run;

  // Calibration: (counts*64 - baseline) * gain, exact
  assign diff   = $signed({1'b0, head.counts, 6'b0}) - $signed({1'b0, baseline_level});
  assign gain_s = $signed({1'b0, gain_factor});
  assign prod   = diff * gain_s;

  // Result sequencing
  always_comb begin
    cur_last    = 1'b1;
    phase_after = PH_RUN_B;
    sel_run     = cur_r.run_b;
    unique case (phase_r)
      PH_SAMPLE: begin
        cur_last    = !cur_r.emit_a && !cur_r.emit_b;
        phase_after = cur_r.emit_a ? PH_RUN_A : PH_RUN_B;
      end
      PH_RUN_A: begin
        cur_last = !cur_r.emit_b;
        sel_run  = cur_r.run_a;
      end
      PH_RUN_B: begin
        cur_last = 1'b1;
      end
      default: begin
        cur_last = 1'b1;
      end
    endcase

    out_load      = !out_valid_r || out_ready;
    emit          = out_load && cur_valid_r;
    cur_take      = !cur_valid_r || (emit && cur_last);
    pop           = cur_take && !q_empty;
    cur_valid_nxt = cur_take ? !q_empty : 1'b1;
    out_valid_nxt = emit ? 1'b1 : (out_load ? 1'b0 : out_valid_r);

    phase_nxt = phase_r;
    if (pop) begin
      phase_nxt = PH_SAMPLE;
    end else if (emit) begin
      phase_nxt = phase_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SAMPLE;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Sample payload and product
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= head;
      volt_r <= prod[VOLT_W-1:0];
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      done_r <= cur_last;
      if (phase_r == PH_SAMPLE) begin
        kind_r  <= 1'b0;
        ovolt_r <= volt_r;
        sst_r   <= cur_r.st;
        rst_r   <= ST_PLAIN;
        first_r <= '0;
        end_r   <= '0;
      end else begin
        kind_r  <= 1'b1;
        ovolt_r <= '0;
        sst_r   <= ST_PLAIN;
        rst_r   <= sel_run.st;
        first_r <= sel_run.first;
        end_r   <= sel_run.stop;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_record_kind   = kind_r;
  assign out_voltage       = ovolt_r;
  assign out_sample_status = sst_r;
  assign out_run_status    = rst_r;
  assign out_run_first     = first_r;
  assign out_run_end       = end_r;
  assign out_item_done     = done_r;

endmodule

// ===== src/digitizer_sample_calibrator.sv =====
// Digitizer sample calibrator: per-sample voltage and status, plus run records.
// Sample result path: queue, current-sample register, then output register.
// Throughput: one sample per cycle while out_ready is high; each run record adds
// a load of the single output register; a 4-entry queue absorbs the bursts.
// Reset (synchronous, rst_n low): queue and output empty, sample index 0,
// registers at baseline 0, gain 0, margins 0, clip 1023, plain runs dropped.
module digitizer_sample_calibrator import dsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COUNT_W-1:0]       in_counts,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_record_kind,
  output logic signed [VOLT_W-1:0] out_voltage,
  output logic [1:0]               out_sample_status,
  output logic [1:0]               out_run_status,
  output logic [IDX_W-1:0]         out_run_first,
  output logic [IDX_W-1:0]         out_run_end,
  output logic                     out_item_done
);

  cfg_t   cfg_r, cfg_nxt;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_in, q_head;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BASELINE:   cfg_nxt.baseline_level    = cfg_wdata[BASE_W-1:0];
        REG_GAIN:       cfg_nxt.gain_factor       = cfg_wdata[GAIN_W-1:0];
        REG_SAT_MARGIN: cfg_nxt.saturation_margin = cfg_wdata[COUNT_W-1:0];
        REG_UND_MARGIN: cfg_nxt.undershoot_margin = cfg_wdata[COUNT_W-1:0];
        REG_CLIP:       cfg_nxt.clip_level        = cfg_wdata[COUNT_W-1:0];
        REG_DROP_PLAIN: cfg_nxt.drop_plain_runs   = cfg_wdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.baseline_level    <= '0;
      cfg_r.gain_factor       <= '0;
      cfg_r.saturation_margin <= '0;
      cfg_r.undershoot_margin <= '0;
      cfg_r.clip_level        <= ADC_MAX;
      cfg_r.drop_plain_runs   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_counts (in_counts),
    .in_last   (in_last),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  dsc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dsc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .baseline_level    (cfg_r.baseline_level),
    .gain_factor       (cfg_r.gain_factor),
    .head              (q_head),
    .q_empty           (q_empty),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_kind   (out_record_kind),
    .out_voltage       (out_voltage),
    .out_sample_status (out_sample_status),
    .out_run_status    (out_run_status),
    .out_run_first     (out_run_first),
    .out_run_end       (out_run_end),
    .out_item_done     (out_item_done)
  );

endmodule
